>>> hdl/tcprt_pkg.sv
// Shared types, codes and reset values for the retransmit timer table.
// Used by every module of the block but tcprt_ram; depends on nothing.
package tcprt_pkg;

  // Default number of connection slots
  localparam int unsigned SlotsDef = 16;
  // Most results reported for one tick
  localparam int unsigned MaxResults = 16;

  // Flag byte bit positions
  localparam int unsigned FlagFin = 0;
  localparam int unsigned FlagSyn = 1;

  // Configuration register indexes
  localparam logic [1:0] CfgRtoInitial = 2'd0;
  localparam logic [1:0] CfgRtoMax     = 2'd1;
  localparam logic [1:0] CfgMaxRetries = 2'd2;

  // Configuration reset values
  localparam logic [15:0] RtoInitialRst = 16'd50;
  localparam logic [15:0] RtoMaxRst     = 16'd3200;
  localparam logic [3:0]  MaxRetriesRst = 4'd5;

  typedef enum logic [1:0] {
    FUNC_ARM    = 2'd0,
    FUNC_ACK    = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_CANCEL = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    EV_NOTHING   = 3'd0,
    EV_ARMED     = 3'd1,
    EV_NOT_ARMED = 3'd2,
    EV_ACKED     = 3'd3,
    EV_RESEND    = 3'd4,
    EV_GIVEN_UP  = 3'd5,
    EV_CANCELLED = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OP,
    ST_WALK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    func_e       func;
    logic [3:0]  slot;
    logic [31:0] now_ticks;
    logic [31:0] seq_start;
    logic [15:0] payload_len;
    logic [7:0]  seg_flags;
    logic [31:0] ack_number;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_slot;
    event_e      event_res;
    logic [3:0]  attempt;
    logic [15:0] new_rto;
    logic [31:0] resend_seq;
    logic [7:0]  resend_flags;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] rto_initial;
    logic [15:0] rto_max;
    logic [3:0]  max_retries;
  } cfg_t;

  // One slot's entry in the timer memory
  typedef struct packed {
    logic [31:0] start_time;
    logic [15:0] timeout;
    logic [3:0]  retry_count;
    logic [31:0] end_sequence;
    logic [31:0] saved_sequence;
    logic [7:0]  saved_flags;
  } ent_t;

endpackage

>>> hdl/tcprt_ram.sv
// Generic single-write, single-read memory with registered read data.
// Standalone; no package needed.
module tcprt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; hold data when no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> hdl/tcprt_cfg.sv
// Configuration registers of the retransmit timer table.
// Depends on tcprt_pkg for the register indexes and reset values.
module tcprt_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  output tcprt_pkg::cfg_t   cfg_o
);

  tcprt_pkg::cfg_t cfg_q, cfg_d;

  // Decode register writes; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tcprt_pkg::CfgRtoInitial: cfg_d.rto_initial = cfg_wdata_i;
        tcprt_pkg::CfgRtoMax:     cfg_d.rto_max     = cfg_wdata_i;
        tcprt_pkg::CfgMaxRetries: cfg_d.max_retries = cfg_wdata_i[3:0];
        default:                  cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rto_initial <= tcprt_pkg::RtoInitialRst;
      cfg_q.rto_max     <= tcprt_pkg::RtoMaxRst;
      cfg_q.max_retries <= tcprt_pkg::MaxRetriesRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/tcprt_engine.sv
// Sequencer and read-modify-write datapath of the retransmit timer table.
// Depends on tcprt_pkg; drives the timer memory held in the top level.
module tcprt_engine #(
  parameter int unsigned SLOTS = tcprt_pkg::SlotsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  tcprt_pkg::cfg_t                         cfg_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  tcprt_pkg::in_item_t                     in_data_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output tcprt_pkg::out_item_t                    out_data_o,
  output logic                                    ram_we_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] ram_waddr_o,
  output tcprt_pkg::ent_t                         ram_wdata_o,
  output logic                                    ram_re_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] ram_raddr_o,
  input  tcprt_pkg::ent_t                         ram_rdata_i
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam logic [CntW-1:0] SlotsCnt = CntW'(SLOTS);
  localparam logic [8:0] SlotsLim = 9'(SLOTS);
  localparam int unsigned NW = $clog2(tcprt_pkg::MaxResults + 1);
  localparam logic [NW-1:0] MaxN = NW'(tcprt_pkg::MaxResults);

  tcprt_pkg::state_e    state_q, state_d;
  tcprt_pkg::in_item_t  item_q, item_d;
  logic [SLOTS-1:0]     pend_q, pend_d;
  logic [IdxW-1:0]      proc_idx_q, proc_idx_d;
  logic [CntW-1:0]      rd_cnt_q, rd_cnt_d;
  logic [NW-1:0]        n_q, n_d;
  logic                 held_v_q, held_v_d;
  tcprt_pkg::out_item_t held_q, held_d;
  logic                 out_v_q, out_v_d;
  tcprt_pkg::out_item_t out_q, out_d;

  tcprt_pkg::ent_t      rd;
  tcprt_pkg::ent_t      wr;
  tcprt_pkg::out_item_t res;
  tcprt_pkg::out_item_t ev;
  logic [8:0]           slot9;
  logic [8:0]           proc9;
  logic                 slot_ok;
  logic [IdxW-1:0]      op_idx;
  logic [IdxW-1:0]      cur_idx;
  logic                 cur_pend;
  logic [3:0]           cur_retry;
  logic [15:0]          cur_rto;
  logic                 syn, fin, arm_go;
  logic [31:0]          end_seq;
  logic [15:0]          arm_rto;
  logic                 ack_hit;
  logic [31:0]          elapsed;
  logic                 expired, give_up, report_ok;
  logic [16:0]          dbl;
  logic [15:0]          bo_rto;
  logic [3:0]           retry_inc;
  logic                 out_free, accept, stall_w;

  // Slot decode and per-slot status from the memory read
  always_comb begin
    rd        = ram_rdata_i;
    slot9     = {5'b0, item_q.slot};
    proc9     = 9'(proc_idx_q);
    slot_ok   = slot9 < SlotsLim;
    op_idx    = slot9[IdxW-1:0];
    cur_idx   = (state_q == tcprt_pkg::ST_WALK) ? proc_idx_q : op_idx;
    cur_pend  = pend_q[cur_idx];
    // retry count is only meaningful while the slot is pending
    cur_retry = cur_pend ? rd.retry_count : 4'd0;
    cur_rto   = cur_pend ? rd.timeout : 16'd0;
  end

  // Arm, ack and expiry arithmetic
  always_comb begin
    syn       = item_q.seg_flags[tcprt_pkg::FlagSyn];
    fin       = item_q.seg_flags[tcprt_pkg::FlagFin];
    arm_go    = syn || fin || (item_q.payload_len != 16'd0);
    end_seq   = item_q.seq_start + 32'(item_q.payload_len) + 32'(syn) + 32'(fin);
    arm_rto   = (cur_retry == 4'd0) ? cfg_i.rto_initial : rd.timeout;
    ack_hit   = cur_pend && (item_q.ack_number >= rd.end_sequence);
    elapsed   = item_q.now_ticks - rd.start_time;
    expired   = cur_pend && (elapsed >= 32'(rd.timeout));
    give_up   = cur_retry >= cfg_i.max_retries;
    dbl       = {rd.timeout, 1'b0};
    bo_rto    = (dbl < {1'b0, cfg_i.rto_max}) ? dbl[15:0] : cfg_i.rto_max;
    retry_inc = cur_retry + 4'd1;
    report_ok = expired && (n_q < MaxN);
  end

  assign out_free   = !out_v_q || !out_stall_i;
  assign in_stall_o = (state_q != tcprt_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  // a walk step that must push the held event waits for the output register
  assign stall_w    = report_ok && held_v_q && !out_free;

  // Next state, memory access and results
  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    pend_d     = pend_q;
    proc_idx_d = proc_idx_q;
    rd_cnt_d   = rd_cnt_q;
    n_d        = n_q;
    held_v_d   = held_v_q;
    held_d     = held_q;
    out_v_d    = out_v_q && out_stall_i;
    out_d      = out_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_idx;
    ram_re_o    = 1'b0;
    ram_raddr_o = op_idx;
    wr          = rd;
    res         = '0;
    ev          = '0;

    case (state_q)
      tcprt_pkg::ST_IDLE: begin
        if (accept) begin
          item_d = in_data_i;
          ram_re_o = 1'b1;
          if (in_data_i.func == tcprt_pkg::FUNC_TICK) begin
            // start the walk at slot 0
            ram_raddr_o = '0;
            proc_idx_d  = '0;
            rd_cnt_d    = CntW'(1);
            n_d         = '0;
            held_v_d    = 1'b0;
            state_d     = tcprt_pkg::ST_WALK;
          end else begin
            ram_raddr_o = 9'({5'b0, in_data_i.slot}) < SlotsLim ?
                          IdxW'(in_data_i.slot) : '0;
            state_d     = tcprt_pkg::ST_OP;
          end
        end
      end

      tcprt_pkg::ST_OP: begin
        if (out_free) begin
          res.out_slot = item_q.slot;
          res.last     = 1'b1;
          if (!slot_ok) begin
            res.event_res = tcprt_pkg::EV_NOTHING;
          end else begin
            case (item_q.func)
              tcprt_pkg::FUNC_ARM: begin
                if (arm_go) begin
                  wr.saved_sequence = item_q.seq_start;
                  wr.end_sequence   = end_seq;
                  wr.saved_flags    = item_q.seg_flags;
                  wr.timeout        = arm_rto;
                  wr.start_time     = item_q.now_ticks;
                  wr.retry_count    = cur_retry;
                  ram_we_o          = 1'b1;
                  pend_d[cur_idx]   = 1'b1;
                  res.event_res     = tcprt_pkg::EV_ARMED;
                  res.attempt       = cur_retry;
                  res.new_rto       = arm_rto;
                  res.resend_seq    = item_q.seq_start;
                  res.resend_flags  = item_q.seg_flags;
                end else begin
                  res.event_res = tcprt_pkg::EV_NOT_ARMED;
                  res.attempt   = cur_retry;
                  res.new_rto   = cur_rto;
                end
              end
              tcprt_pkg::FUNC_ACK: begin
                if (ack_hit) begin
                  pend_d[cur_idx] = 1'b0;
                  res.event_res   = tcprt_pkg::EV_ACKED;
                end else begin
                  res.event_res = tcprt_pkg::EV_NOTHING;
                  res.attempt   = cur_retry;
                  res.new_rto   = cur_rto;
                end
              end
              tcprt_pkg::FUNC_CANCEL: begin
                pend_d[cur_idx] = 1'b0;
                res.event_res   = tcprt_pkg::EV_CANCELLED;
              end
              default: begin
                res.event_res = tcprt_pkg::EV_NOTHING;
              end
            endcase
          end
          out_d   = res;
          out_v_d = 1'b1;
          state_d = tcprt_pkg::ST_IDLE;
        end
      end

      tcprt_pkg::ST_WALK: begin
        if (!stall_w) begin
          // handle the slot whose entry was just read
          ev.out_slot = proc9[3:0];
          if (expired) begin
            if (give_up) begin
              pend_d[cur_idx] = 1'b0;
              ev.event_res    = tcprt_pkg::EV_GIVEN_UP;
            end else begin
              wr.retry_count  = retry_inc;
              wr.timeout      = bo_rto;
              wr.start_time   = item_q.now_ticks;
              ram_we_o        = 1'b1;
              ev.event_res    = tcprt_pkg::EV_RESEND;
              ev.attempt      = retry_inc;
              ev.new_rto      = bo_rto;
              ev.resend_seq   = rd.saved_sequence;
              ev.resend_flags = rd.saved_flags;
            end
          end
          // hold the newest event back until we know whether it is the last
          if (report_ok) begin
            n_d      = n_q + NW'(1);
            held_d   = ev;
            held_v_d = 1'b1;
            if (held_v_q) begin
              out_d   = held_q;
              out_v_d = 1'b1;
            end
          end
          // advance to the next slot
          if (rd_cnt_q == SlotsCnt) begin
            state_d = tcprt_pkg::ST_FLUSH;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = rd_cnt_q[IdxW-1:0];
            proc_idx_d  = rd_cnt_q[IdxW-1:0];
            rd_cnt_d    = rd_cnt_q + CntW'(1);
          end
        end
      end

      tcprt_pkg::ST_FLUSH: begin
        if (out_free) begin
          if (held_v_q) begin
            res = held_q;
          end else begin
            res.event_res = tcprt_pkg::EV_NOTHING;
          end
          res.last = 1'b1;
          out_d    = res;
          out_v_d  = 1'b1;
          held_v_d = 1'b0;
          state_d  = tcprt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tcprt_pkg::ST_IDLE;
      end
    endcase

    ram_wdata_o = wr;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tcprt_pkg::ST_IDLE;
      pend_q     <= '0;
      proc_idx_q <= '0;
      rd_cnt_q   <= '0;
      n_q        <= '0;
      held_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_q     <= pend_d;
      proc_idx_q <= proc_idx_d;
      rd_cnt_q   <= rd_cnt_d;
      n_q        <= n_d;
      held_v_q   <= held_v_d;
      out_v_q    <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    held_q <= held_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/tcp_retransmit_timer_table_core.sv
// Retransmit timer table: per-slot timers with exponential backoff.
// For an arm, ack or cancel, the accept cycle reads the slot's entry from
// the timer memory; then, once the output register is free, the op state
// modifies it, writes it back and loads the result. A tick walks all SLOTS
// slots through the single memory read port, one slot per cycle unless a
// stalled output holds the walk; a flush state then loads the last result.
// Each tick yields one result per expired slot (at most 16 reported), or
// one "nothing" result. Results leave through an output register, so a
// stalled output only holds the walk when a second event must be pushed
// out. The timer memory needs no clearing after reset: per-slot pending
// bits in flip-flops gate every read of it.
// Depends on tcprt_pkg, tcprt_cfg, tcprt_engine and tcprt_ram.
module tcp_retransmit_timer_table_core #(
  parameter int unsigned SLOTS = tcprt_pkg::SlotsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tcprt_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tcprt_pkg::out_item_t out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned EntW = $bits(tcprt_pkg::ent_t);

  tcprt_pkg::cfg_t cfg;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  tcprt_pkg::ent_t ram_wdata;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  logic [EntW-1:0] ram_rdata;

  // Configuration registers
  tcprt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Per-slot timer entries
  tcprt_ram #(
    .Width (EntW),
    .Depth (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer and datapath
  tcprt_engine #(
    .SLOTS (SLOTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (tcprt_pkg::ent_t'(ram_rdata))
  );

endmodule

>>> test/tcp_retransmit_timer_table_core_tb.sv
`timescale 1ns / 1ps
// Testbench for tcp_retransmit_timer_table_core: a directed table, then random arms, acks,
// ticks and cancels over several register settings, checked by a predictor or typed rows.
// Depends on tcprt_pkg and the block's RTL.
module tcp_retransmit_timer_table_core_tb;
  import tcprt_pkg::*;

  localparam int          Slots       = SlotsDef;
  localparam int          ClkPeriod   = 10;
  localparam int          LimitCycles = 500_000;
  localparam int          HoldCycles  = 300;
  localparam int          NumPhases   = 6;
  localparam logic [1:0]  CfgUnused   = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  // Predicted timer table and register copy
  logic        slot_pending [Slots];
  logic [31:0] slot_start   [Slots];
  logic [15:0] slot_rto     [Slots];
  logic [3:0]  slot_tries   [Slots];
  logic [31:0] slot_end     [Slots];
  logic [31:0] slot_seq     [Slots];
  logic [7:0]  slot_flags   [Slots];
  cfg_t        cfg_model;

  out_item_t   step_events[$];
  out_item_t   timer_events_due[$];
  int          err_cnt = 0;

  // Stimulus shaping shared between processes
  bit          idle_on;
  bit          hold_req;
  bit          hold_done;
  int unsigned tick_span;
  logic [31:0] wall_now;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  dir_row_t    dir_rows[$];
  cfg_t        phase_cfg  [NumPhases];
  int unsigned phase_span [NumPhases];

  tcp_retransmit_timer_table_core #(
    .SLOTS(Slots)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic out_item_t mk_res(logic [3:0] s, event_e ev, logic [3:0] att,
                                       logic [15:0] rto, logic [31:0] seq, logic [7:0] fl,
                                       logic lst);
    out_item_t r;
    r.out_slot     = s;
    r.event_res    = ev;
    r.attempt      = att;
    r.new_rto      = rto;
    r.resend_seq   = seq;
    r.resend_flags = fl;
    r.last         = lst;
    return r;
  endfunction

  function automatic in_item_t mk_item(func_e f, logic [3:0] s, logic [31:0] now,
                                       logic [31:0] seq, logic [15:0] len, logic [7:0] fl,
                                       logic [31:0] ack);
    in_item_t it;
    it.func        = f;
    it.slot        = s;
    it.now_ticks   = now;
    it.seq_start   = seq;
    it.payload_len = len;
    it.seg_flags   = fl;
    it.ack_number  = ack;
    return it;
  endfunction

  task automatic add_row(input in_item_t it, input bit typed, input out_item_t res);
    dir_rows.push_back('{it, typed, res});
  endtask

  // Advance the timer table by one item and collect the events it reports
  task automatic predict_timer_step(input in_item_t it);
    logic [31:0] elapsed;
    logic [16:0] dbl;
    logic        syn;
    logic        fin;
    logic [3:0]  s;
    out_item_t   r;
    s = it.slot;
    step_events.delete();
    case (it.func)
      FUNC_TICK: begin
        for (int i = 0; i < Slots; i++) begin
          elapsed = it.now_ticks - slot_start[i];
          if (!slot_pending[i] || elapsed < {16'd0, slot_rto[i]}) continue;
          if (slot_tries[i] >= cfg_model.max_retries) begin
            // give up and free the slot
            slot_pending[i] = 1'b0;
            slot_tries[i]   = 4'd0;
            r = mk_res(4'(i), EV_GIVEN_UP, 4'd0, 16'd0, 32'd0, 8'd0, 1'b0);
          end else begin
            // back off: double the timeout, saturate at the ceiling, restart the timer
            dbl = {slot_rto[i], 1'b0};
            slot_tries[i] = slot_tries[i] + 4'd1;
            slot_rto[i]   = (dbl < {1'b0, cfg_model.rto_max}) ? dbl[15:0] : cfg_model.rto_max;
            slot_start[i] = it.now_ticks;
            r = mk_res(4'(i), EV_RESEND, slot_tries[i], slot_rto[i], slot_seq[i],
                       slot_flags[i], 1'b0);
          end
          if (step_events.size() < MaxResults) step_events.push_back(r);
        end
        if (step_events.size() == 0) begin
          step_events.push_back(mk_res(4'd0, EV_NOTHING, 4'd0, 16'd0, 32'd0, 8'd0, 1'b0));
        end
      end
      FUNC_ARM: begin
        syn = it.seg_flags[FlagSyn];
        fin = it.seg_flags[FlagFin];
        if (syn || fin || it.payload_len != 16'd0) begin
          slot_seq[s]     = it.seq_start;
          slot_end[s]     = it.seq_start + 32'(it.payload_len) + 32'(syn) + 32'(fin);
          slot_flags[s]   = it.seg_flags;
          if (slot_tries[s] == 4'd0) slot_rto[s] = cfg_model.rto_initial;
          slot_start[s]   = it.now_ticks;
          slot_pending[s] = 1'b1;
          r = mk_res(s, EV_ARMED, slot_tries[s], slot_rto[s], slot_seq[s], slot_flags[s], 1'b0);
        end else begin
          r = mk_res(s, EV_NOT_ARMED, slot_tries[s], slot_pending[s] ? slot_rto[s] : 16'd0,
                     32'd0, 8'd0, 1'b0);
        end
        step_events.push_back(r);
      end
      FUNC_ACK: begin
        if (slot_pending[s] && it.ack_number >= slot_end[s]) begin
          slot_pending[s] = 1'b0;
          slot_tries[s]   = 4'd0;
          r = mk_res(s, EV_ACKED, 4'd0, 16'd0, 32'd0, 8'd0, 1'b0);
        end else begin
          r = mk_res(s, EV_NOTHING, slot_tries[s], slot_pending[s] ? slot_rto[s] : 16'd0,
                     32'd0, 8'd0, 1'b0);
        end
        step_events.push_back(r);
      end
      default: begin
        slot_pending[s] = 1'b0;
        slot_tries[s]   = 4'd0;
        step_events.push_back(mk_res(s, EV_CANCELLED, 4'd0, 16'd0, 32'd0, 8'd0, 1'b0));
      end
    endcase
    // mark the final event of this item
    r = step_events.pop_back();
    r.last = 1'b1;
    step_events.push_back(r);
  endtask

  // Offer one item after a random gap, hold it until taken, then queue its events
  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_timer_step(it);
    if (typed) begin
      timer_events_due.push_back(typed_res);
    end else begin
      foreach (step_events[k]) timer_events_due.push_back(step_events[k]);
    end
  endtask

  // Write one register while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    case (idx)
      CfgRtoInitial: cfg_model.rto_initial = val;
      CfgRtoMax:     cfg_model.rto_max     = val;
      CfgMaxRetries: cfg_model.max_retries = val[3:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Compare each taken result with the oldest outstanding event
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (timer_events_due.size() == 0) begin
        err_cnt++;
        $display("%0t: expected no result, got %h", $time, out_data_o);
      end else begin
        want = timer_events_due.pop_front();
        check_field("out_slot", 32'(want.out_slot), 32'(out_data_o.out_slot));
        check_field("event_res", 32'(want.event_res), 32'(out_data_o.event_res));
        check_field("attempt", 32'(want.attempt), 32'(out_data_o.attempt));
        check_field("new_rto", 32'(want.new_rto), 32'(out_data_o.new_rto));
        check_field("resend_seq", want.resend_seq, out_data_o.resend_seq);
        check_field("resend_flags", 32'(want.resend_flags), 32'(out_data_o.resend_flags));
        check_field("last", 32'(want.last), 32'(out_data_o.last));
      end
    end
  end

  // Receiver: random stalls per result, plus one long hold-off on request
  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      n = idle_on ? $urandom_range(0, 9) : 0;
      if (hold_req && !hold_done) begin
        n = HoldCycles;
        hold_done = 1'b1;
      end
      if (n > 0) begin
        @(negedge clk_i);
        out_stall_i = 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  initial begin
    #(LimitCycles * ClkPeriod);
    $display("tcp_retransmit_timer_table_core_tb: errors");
    $finish;
  end

  initial begin
    in_item_t     it;
    logic [127:0] junk;
    int unsigned  pick;
    int unsigned  sel;
    logic [3:0]   s;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgRtoInitial;
    cfg_wdata_i = '0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    tick_span   = 1;
    wall_now    = '0;
    cfg_model   = '{RtoInitialRst, RtoMaxRst, MaxRetriesRst};
    for (int i = 0; i < Slots; i++) begin
      slot_pending[i] = 1'b0;
      slot_start[i]   = '0;
      slot_rto[i]     = '0;
      slot_tries[i]   = '0;
      slot_end[i]     = '0;
      slot_seq[i]     = '0;
      slot_flags[i]   = '0;
    end

    // Register settings per phase: defaults, low extremes, high extremes, then mixes
    phase_cfg = '{
      '{RtoInitialRst, RtoMaxRst, MaxRetriesRst},
      '{16'd1, 16'd1, 4'd0},
      '{16'd65535, 16'd65535, 4'd15},
      '{16'd2, 16'd40, 4'd3},
      '{16'd5, 16'd65535, 4'd15},
      '{16'd30000, 16'd65535, 4'd2}
    };
    phase_span = '{60, 3, 40000, 30, 300, 50000};

    // Directed rows at reset settings
    add_row(mk_item(FUNC_TICK, 0, 0, 0, 0, 0, 0), 1,
            mk_res(0, EV_NOTHING, 0, 0, 0, 0, 1));
    add_row(mk_item(FUNC_ACK, 0, 0, 0, 0, 0, 0), 1,
            mk_res(0, EV_NOTHING, 0, 0, 0, 0, 1));
    // no SYN, no FIN, no payload: nothing to time
    add_row(mk_item(FUNC_ARM, 0, 10, 123, 0, 8'hFC, 0), 1,
            mk_res(0, EV_NOT_ARMED, 0, 0, 0, 0, 1));
    // end sequence wraps past 2^32
    add_row(mk_item(FUNC_ARM, 0, 100, 32'hFFFF_FFFF, 16'hFFFF, 8'h03, 0), 1,
            mk_res(0, EV_ARMED, 0, RtoInitialRst, 32'hFFFF_FFFF, 8'h03, 1));
    add_row(mk_item(FUNC_ARM, 15, 100, 1000, 0, 8'h02, 0), 1,
            mk_res(15, EV_ARMED, 0, RtoInitialRst, 1000, 8'h02, 1));
    add_row(mk_item(FUNC_ARM, 7, 120, 0, 1, 8'hFC, 0), 1,
            mk_res(7, EV_ARMED, 0, RtoInitialRst, 0, 8'hFC, 1));
    // plain compare: below the wrapped end does not clear
    add_row(mk_item(FUNC_ACK, 0, 0, 0, 0, 0, 32'h0000_FFFF), 1,
            mk_res(0, EV_NOTHING, 0, RtoInitialRst, 0, 0, 1));
    add_row(mk_item(FUNC_TICK, 0, 149, 0, 0, 0, 0), 1,
            mk_res(0, EV_NOTHING, 0, 0, 0, 0, 1));
    add_row(mk_item(FUNC_TICK, 0, 150, 0, 0, 0, 0), 0, '0);
    // re-arm of a pending slot with retries keeps its timeout
    add_row(mk_item(FUNC_ARM, 0, 160, 2000, 0, 8'h01, 0), 0, '0);
    add_row(mk_item(FUNC_ACK, 15, 0, 0, 0, 0, 32'hFFFF_FFFF), 1,
            mk_res(15, EV_ACKED, 0, 0, 0, 0, 1));
    add_row(mk_item(FUNC_CANCEL, 7, 0, 0, 0, 0, 0), 1,
            mk_res(7, EV_CANCELLED, 0, 0, 0, 0, 1));
    // cancel of an idle slot
    add_row(mk_item(FUNC_CANCEL, 3, 0, 0, 0, 0, 0), 1,
            mk_res(3, EV_CANCELLED, 0, 0, 0, 0, 1));
    add_row(mk_item(FUNC_ARM, 9, 32'hFFFF_FFF0, 32'h8000_0000, 10, 8'h00, 0), 1,
            mk_res(9, EV_ARMED, 0, RtoInitialRst, 32'h8000_0000, 8'h00, 1));
    // elapsed time across the wrap of the tick counter
    add_row(mk_item(FUNC_TICK, 0, 32'h22, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(FUNC_ACK, 9, 0, 0, 0, 0, 32'h8000_0009), 0, '0);
    // ack exactly at the end sequence clears
    add_row(mk_item(FUNC_ACK, 9, 0, 0, 0, 0, 32'h8000_000A), 1,
            mk_res(9, EV_ACKED, 0, 0, 0, 0, 1));
    add_row(mk_item(FUNC_ACK, 0, 0, 0, 0, 0, 0), 0, '0);
    // back off slot 0 until it runs out of retries
    add_row(mk_item(FUNC_TICK, 0, 234, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(FUNC_TICK, 0, 634, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(FUNC_TICK, 0, 1434, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(FUNC_TICK, 0, 3034, 0, 0, 0, 0), 1,
            mk_res(0, EV_GIVEN_UP, 0, 0, 0, 0, 1));
    add_row(mk_item(FUNC_ACK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1,
            mk_res(0, EV_NOTHING, 0, 0, 0, 0, 1));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      // reprogram only while idle
      if (p > 0) begin
        write_reg(CfgRtoInitial, phase_cfg[p].rto_initial);
        write_reg(CfgRtoMax, phase_cfg[p].rto_max);
        write_reg(CfgMaxRetries, 16'(phase_cfg[p].max_retries));
      end
      if (p == 1) write_reg(CfgUnused, 16'hFFFF);
      idle_on   = (p != 4);
      tick_span = phase_span[p];
      wall_now  = (p == 1) ? 32'hFFFF_FFF0 : $urandom;
      if (p == 3) hold_req = 1'b1;

      if (p == 0) begin
        foreach (dir_rows[k]) offer_item(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].res);
      end

      // Random traffic: arms and acks aimed at live end sequences, ticks on a running clock
      repeat ((p == 0) ? 60 : 75) begin
        junk = {$urandom, $urandom, $urandom, $urandom};
        it   = junk[$bits(in_item_t)-1:0];
        s    = it.slot;
        wall_now     = wall_now + $urandom_range(0, tick_span);
        it.now_ticks = wall_now;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 9);
        if (pick < 30) begin
          it.func = FUNC_ARM;
          if (sel == 0) begin
            it.payload_len       = '0;
            it.seg_flags[FlagSyn] = 1'b0;
            it.seg_flags[FlagFin] = 1'b0;
          end else if (sel < 8) begin
            it.payload_len = 16'($urandom_range(0, 1460));
          end
        end else if (pick < 55) begin
          it.func = FUNC_ACK;
          if (sel < 4) it.ack_number = slot_end[s];
          else if (sel < 6) it.ack_number = slot_end[s] - 32'd1;
          else if (sel < 8) it.ack_number = slot_end[s] + $urandom_range(1, 1000);
        end else if (pick < 90) begin
          it.func = FUNC_TICK;
        end else begin
          it.func = FUNC_CANCEL;
        end
        offer_item(it, 1'b0, '0);
      end

      @(negedge clk_i);
      in_valid_i = 1'b0;
      while (timer_events_due.size() != 0) @(posedge clk_i);
    end

    repeat (Slots + 4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tcp_retransmit_timer_table_core_tb: clean");
    end else begin
      $display("tcp_retransmit_timer_table_core_tb: errors");
    end
    $finish;
  end

endmodule
